@@ sv/assert_macros.svh @@
// Assertion macros for the verification checker of this project.
// Each macro expands to one labeled concurrent assertion on i_clk that is
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VT4_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold after the antecedent, delayed by the argument n.
`define VT4_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##n (cons)) else $error(msg);

`endif

@@ sv/vt4_pkg.sv @@
// Package for the 4x4 vector transform: register map constants and types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vt4_pkg;

    localparam int NUM_REGS   = 8;
    localparam int REG_WIDTH  = 32;
    localparam int COEF_WIDTH = 16;
    localparam int NUM_LANES  = 4;
    localparam int IDX_WIDTH  = $clog2(NUM_REGS);
    localparam int ADDR_WIDTH = IDX_WIDTH + 2;

    typedef logic [REG_WIDTH-1:0]                 t_reg;
    typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0]   t_reg_file;
    typedef logic [NUM_LANES-1:0][COEF_WIDTH-1:0] t_coef_set;
    typedef logic [ADDR_WIDTH-1:0]                t_addr;

    // The reset matrix is the identity, with 1.0 equal to 4096.
    localparam t_reg_file REG_RESET = {
        32'h1000_0000, 32'h0000_0000, 32'h0000_1000, 32'h0000_0000,
        32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 32'h0000_1000
    };

endpackage

`default_nettype wire

@@ sv/vt4_regs.sv @@
// Coefficient register file behind the APB-style configuration port.
// Depends on vt4_pkg for the register map and reset values.
`default_nettype none

module vt4_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  vt4_pkg::t_addr    paddr,
    input  vt4_pkg::t_reg     pwdata,
    output vt4_pkg::t_reg     prdata,
    output logic              pready,
    output vt4_pkg::t_reg_file o_regs
);
    import vt4_pkg::*;

    t_reg_file              r_regs;
    logic [IDX_WIDTH-1:0]   idx;
    logic                   wr_en;

    assign idx    = paddr[ADDR_WIDTH-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = r_regs[idx];
    assign o_regs = r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= REG_RESET;
        end else if (wr_en) begin
            r_regs[idx] <= pwdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/vt4_lane.sv @@
// One lane: four products, their sum, rounding, shift and saturation.
// Depends on vt4_pkg for coefficient widths and lane count.
`default_nettype none

module vt4_lane #(
    parameter int DATA_WIDTH     = 16,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                                            i_clk,
    input  logic [vt4_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0]   i_vec,
    input  vt4_pkg::t_coef_set                              i_coef,
    output logic [DATA_WIDTH-1:0]                           o_res,
    output logic                                            o_sat
);
    import vt4_pkg::*;

    localparam int PW = DATA_WIDTH + COEF_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW:0] RND  = (SW+1)'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [SW:0] MAXV = (SW+1)'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW:0] MINV = ~MAXV;

    logic signed [PW-1:0] r_prod [NUM_LANES];
    logic signed [PW-1:0] n_prod [NUM_LANES];
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;
    logic signed [SW:0]   rnd;
    logic signed [SW:0]   shd;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_prod[k] = PW'($signed(i_coef[k])) * PW'($signed(i_vec[k]));
        end
        n_sum = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]) + SW'(r_prod[3]);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_sum  <= n_sum;
    end

    always_comb begin
        rnd = (SW+1)'(r_sum) + RND;
        shd = rnd >>> COEF_FRAC_BITS;
        if (shd > MAXV) begin
            o_res = DATA_WIDTH'(MAXV);
            o_sat = 1'b1;
        end else if (shd < MINV) begin
            o_res = DATA_WIDTH'(MINV);
            o_sat = 1'b1;
        end else begin
            o_res = DATA_WIDTH'(shd);
            o_sat = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ sv/vt4_merge.sv @@
// Merging stage: registers the four lane results and folds their
// saturation flags into one clipped flag. Depends on vt4_pkg.
`default_nettype none

module vt4_merge #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  logic [vt4_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0]   i_res,
    input  logic [vt4_pkg::NUM_LANES-1:0]                   i_sat,
    output logic                                            o_valid,
    output logic [vt4_pkg::NUM_LANES-1:0][DATA_WIDTH-1:0]   o_res,
    output logic                                            o_clipped
);
    import vt4_pkg::*;

    logic                                   r_valid;
    logic [NUM_LANES-1:0][DATA_WIDTH-1:0]   r_res;
    logic                                   r_clipped;
    logic                                   n_clipped;

    assign n_clipped = |i_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res     <= i_res;
        r_clipped <= n_clipped;
    end

    assign o_valid   = r_valid;
    assign o_res     = r_res;
    assign o_clipped = r_clipped;

endmodule

`default_nettype wire

@@ sv/vector_transform_4x4.sv @@
// Path: an accepted word passes the product, sum and merge output registers and
// appears on the result ports, with o_done high, for a single cycle.
// Throughput: one word per cycle; busy is never raised, since the four lanes
// are fully pipelined (products, sum, round and saturate, output register).
// Reset: synchronous, active low; clears the pipeline valid bits and loads
// the identity matrix into the coefficient registers.
`default_nettype none

module vector_transform_4x4 #(
    parameter int DATA_WIDTH     = 16,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [DATA_WIDTH-1:0]  i_vec_x,
    input  logic signed [DATA_WIDTH-1:0]  i_vec_y,
    input  logic signed [DATA_WIDTH-1:0]  i_vec_z,
    input  logic signed [DATA_WIDTH-1:0]  i_vec_w,
    output logic                          o_done,
    output logic signed [DATA_WIDTH-1:0]  o_out_x,
    output logic signed [DATA_WIDTH-1:0]  o_out_y,
    output logic signed [DATA_WIDTH-1:0]  o_out_z,
    output logic signed [DATA_WIDTH-1:0]  o_out_w,
    output logic                          o_clipped,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  vt4_pkg::t_addr                paddr,
    input  vt4_pkg::t_reg                 pwdata,
    output vt4_pkg::t_reg                 prdata,
    output logic                          pready
);
    import vt4_pkg::*;

    t_reg_file                              regs;
    logic [NUM_LANES-1:0][DATA_WIDTH-1:0]   vec;
    t_coef_set                              coef [NUM_LANES];
    logic [NUM_LANES-1:0][DATA_WIDTH-1:0]   lane_res;
    logic [NUM_LANES-1:0]                   lane_sat;
    logic [NUM_LANES-1:0][DATA_WIDTH-1:0]   out_res;
    logic                                   accept;
    logic                                   r_v1;
    logic                                   r_v2;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign vec    = {i_vec_w, i_vec_z, i_vec_y, i_vec_x};

    vt4_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_regs  (regs)
    );

    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        for (genvar k = 0; k < NUM_LANES; k++) begin : g_coef
            assign coef[j][k] = regs[2*k + (j >> 1)][COEF_WIDTH*(j & 1) +: COEF_WIDTH];
        end

        vt4_lane #(
            .DATA_WIDTH     (DATA_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_vec  (vec),
            .i_coef (coef[j]),
            .o_res  (lane_res[j]),
            .o_sat  (lane_sat[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    vt4_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v2),
        .i_res     (lane_res),
        .i_sat     (lane_sat),
        .o_valid   (o_done),
        .o_res     (out_res),
        .o_clipped (o_clipped)
    );

    assign o_out_x = out_res[0];
    assign o_out_y = out_res[1];
    assign o_out_z = out_res[2];
    assign o_out_w = out_res[3];

endmodule

`default_nettype wire

@@ sv/vt4_checker.sv @@
// Port-level checker for the 4x4 vector transform, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"
`default_nettype none

module vt4_checker #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_done,
    input  logic signed [DATA_WIDTH-1:0]  o_out_x,
    input  logic signed [DATA_WIDTH-1:0]  o_out_y,
    input  logic signed [DATA_WIDTH-1:0]  o_out_z,
    input  logic signed [DATA_WIDTH-1:0]  o_out_w,
    input  logic                          o_clipped
);

    localparam logic signed [DATA_WIDTH-1:0] MAXV = DATA_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [DATA_WIDTH-1:0] MINV = ~MAXV;

    logic any_limit;

    assign any_limit = (o_out_x == MAXV) || (o_out_x == MINV) ||
                       (o_out_y == MAXV) || (o_out_y == MINV) ||
                       (o_out_z == MAXV) || (o_out_z == MINV) ||
                       (o_out_w == MAXV) || (o_out_w == MINV);

    `VT4_ASSERT_SAME(a_never_busy, 1'b1, !busy, "busy raised by a fully pipelined block")
    `VT4_ASSERT_DELAY(a_done_follows, start && !busy, 3, o_done, "accepted word gave no result")
    `VT4_ASSERT_SAME(a_done_has_word, o_done, $past(start && !busy, 3), "result without a word")
    `VT4_ASSERT_SAME(a_clip_at_limit, o_done && o_clipped, any_limit, "clipped with no limit")

endmodule

bind vector_transform_4x4 vt4_checker #(.DATA_WIDTH(DATA_WIDTH)) u_vt4_checker (.*);

`default_nettype wire

@@ sim/vector_transform_4x4_test.sv @@
// Self-checking testbench for the 4x4 vector transform: it drives words and APB register
// writes, predicts every transformed word and compares each result field by field.
// Depends on vt4_pkg and vector_transform_4x4.
`default_nettype none

module vector_transform_4x4_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW         = 16;
    localparam int FRAC       = 12;
    localparam int LATENCY    = 3;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 100;

    typedef logic signed [DW-1:0] t_comp;

    typedef struct {
        t_comp lane [4];
    } t_vec;

    typedef struct {
        t_comp lane [4];
        bit    clip;
    } t_result;

    typedef enum int {
        MAT_RANDOM,
        MAT_ALL_MAX,
        MAT_ALL_MIN,
        MAT_ZERO,
        MAT_SMALL,
        MAT_EXTREME_MIX
    } t_mat_kind;

    class transform_scoreboard;
        logic [31:0] coef_regs [8];
        t_result     pending_results [$];
        int          n_errors;
        int          n_words;
        int          n_clipped;

        function new();
            reset_coefs();
        endfunction

        function void reset_coefs();
            coef_regs[0] = 32'h0000_1000;
            coef_regs[1] = 32'h0000_0000;
            coef_regs[2] = 32'h1000_0000;
            coef_regs[3] = 32'h0000_0000;
            coef_regs[4] = 32'h0000_0000;
            coef_regs[5] = 32'h0000_1000;
            coef_regs[6] = 32'h0000_0000;
            coef_regs[7] = 32'h1000_0000;
        endfunction

        function void write_coef(int idx, logic [31:0] value);
            coef_regs[idx] = value;
        endfunction

        function void report_mismatch(string what);
            $display("mismatch: %s", what);
            n_errors++;
        endfunction

        function t_result transform(t_vec v);
            t_result     res;
            logic [31:0] r;
            t_comp       c;
            longint      acc;
            longint      max_val;
            longint      min_val;
            max_val = (64'sd1 <<< (DW - 1)) - 1;
            min_val = -max_val - 1;
            res.clip = 1'b0;
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) begin
                    r = coef_regs[2 * k + j / 2];
                    c = (j % 2 == 1) ? r[31:16] : r[15:0];
                    acc += longint'(c) * longint'(v.lane[k]);
                end
                acc += 64'sd1 <<< (FRAC - 1);
                acc = acc >>> FRAC;
                if (acc > max_val) begin
                    acc = max_val;
                    res.clip = 1'b1;
                end else if (acc < min_val) begin
                    acc = min_val;
                    res.clip = 1'b1;
                end
                res.lane[j] = t_comp'(acc);
            end
            return res;
        endfunction

        function void note_input(t_vec v);
            pending_results.push_back(transform(v));
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                report_mismatch("result word with no word outstanding");
                return;
            end
            exp = pending_results.pop_front();
            n_words++;
            if (got.clip) n_clipped++;
            for (int j = 0; j < 4; j++) begin
                if (got.lane[j] !== exp.lane[j]) begin
                    report_mismatch($sformatf("word %0d lane %0d got %0d expected %0d",
                        n_words, j, got.lane[j], exp.lane[j]));
                end
            end
            if (got.clip !== exp.clip) begin
                report_mismatch($sformatf("word %0d clipped got %0b expected %0b",
                    n_words, got.clip, exp.clip));
            end
        endfunction
    endclass

    transform_scoreboard sb = new();

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    t_comp          i_vec_x, i_vec_y, i_vec_z, i_vec_w;
    logic           o_done;
    t_comp          o_out_x, o_out_y, o_out_z, o_out_w;
    logic           o_clipped;
    logic           psel;
    logic           penable;
    logic           pwrite;
    vt4_pkg::t_addr paddr;
    vt4_pkg::t_reg  pwdata;
    vt4_pkg::t_reg  prdata;
    logic           pready;

    int      n_settings;
    int      idle_cycles;
    t_result got_word;

    vector_transform_4x4 #(
        .DATA_WIDTH    (DW),
        .COEF_FRAC_BITS(FRAC)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_vec_x  (i_vec_x),
        .i_vec_y  (i_vec_y),
        .i_vec_z  (i_vec_z),
        .i_vec_w  (i_vec_w),
        .o_done   (o_done),
        .o_out_x  (o_out_x),
        .o_out_y  (o_out_y),
        .o_out_z  (o_out_z),
        .o_out_w  (o_out_w),
        .o_clipped(o_clipped),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_vec make_vec(int x, int y, int z, int w);
        t_vec v;
        v.lane[0] = t_comp'(x);
        v.lane[1] = t_comp'(y);
        v.lane[2] = t_comp'(z);
        v.lane[3] = t_comp'(w);
        return v;
    endfunction

    function automatic t_comp pick_extreme();
        case ($urandom_range(0, 4))
            0: return t_comp'(16'h7FFF);
            1: return t_comp'(16'h8000);
            2: return t_comp'(0);
            3: return t_comp'(1);
            default: return t_comp'(-1);
        endcase
    endfunction

    function automatic t_vec random_vec();
        t_vec v;
        int   kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++) begin
            if (kind < 6) begin
                v.lane[k] = t_comp'($urandom);
            end else if (kind < 8) begin
                v.lane[k] = pick_extreme();
            end else begin
                v.lane[k] = t_comp'($signed($urandom_range(0, 64)) - 32);
            end
        end
        return v;
    endfunction

    function automatic logic [15:0] coef_half(t_mat_kind kind);
        case (kind)
            MAT_ALL_MAX: return 16'h7FFF;
            MAT_ALL_MIN: return 16'h8000;
            MAT_ZERO:    return 16'h0000;
            MAT_SMALL:   return 16'($signed($urandom_range(0, 8192)) - 4096);
            MAT_EXTREME_MIX: begin
                case ($urandom_range(0, 5))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h1000;
                    4: return 16'hF000;
                    default: return 16'($urandom);
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic apb_write(int idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = vt4_pkg::t_addr'(idx * 4);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        sb.write_coef(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(int idx);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = vt4_pkg::t_addr'(idx * 4);
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        if (prdata !== sb.coef_regs[idx]) begin
            sb.report_mismatch($sformatf("register %0d read %h expected %h",
                idx, prdata, sb.coef_regs[idx]));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic load_matrix(logic [31:0] regs [8]);
        wait_drained();
        for (int i = 0; i < 8; i++) apb_write(i, regs[i]);
        for (int i = 0; i < 8; i++) apb_read_check(i);
        n_settings++;
    endtask

    task automatic load_uniform(logic [15:0] c);
        logic [31:0] regs [8];
        for (int i = 0; i < 8; i++) regs[i] = {c, c};
        load_matrix(regs);
    endtask

    task automatic send_word(t_vec v);
        @(negedge i_clk);
        start   = 1'b1;
        i_vec_x = v.lane[0];
        i_vec_y = v.lane[1];
        i_vec_z = v.lane[2];
        i_vec_w = v.lane[3];
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_input(v);
    endtask

    task automatic idle_sender(int n);
        repeat (n) begin
            @(negedge i_clk);
            start   = 1'b0;
            i_vec_x = t_comp'($urandom);
            i_vec_y = t_comp'($urandom);
            i_vec_z = t_comp'($urandom);
            i_vec_w = t_comp'($urandom);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            got_word.lane[0] = o_out_x;
            got_word.lane[1] = o_out_y;
            got_word.lane[2] = o_out_z;
            got_word.lane[3] = o_out_w;
            got_word.clip    = o_clipped;
            sb.check_result(got_word);
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done || (psel && penable)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Timed out with %0d words outstanding.", sb.pending_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin : main
        logic [31:0] regs [8];
        t_mat_kind   kind;
        bit          no_gaps;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_vec_x    = '0;
        i_vec_y    = '0;
        i_vec_z    = '0;
        i_vec_w    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        n_settings = 1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Identity matrix out of reset.
        for (int i = 0; i < 8; i++) apb_read_check(i);
        send_word(make_vec(0, 0, 0, 0));
        send_word(make_vec(32767, 32767, 32767, 32767));
        send_word(make_vec(-32768, -32768, -32768, -32768));
        send_word(make_vec(32767, -32768, 1, -1));
        send_word(make_vec(1, -1, 0, 12345));
        idle_sender(1);

        // A diagonal of one half puts the sums of odd components exactly on the rounding point.
        regs = '{32'h0000_0800, 32'h0, 32'h0800_0000, 32'h0,
                 32'h0, 32'h0000_0800, 32'h0, 32'h0800_0000};
        load_matrix(regs);
        send_word(make_vec(1, -1, 3, -3));
        send_word(make_vec(32767, -32768, 2, -2));
        send_word(make_vec(5, -5, -7, 7));
        idle_sender(1);

        load_uniform(16'h7FFF);
        send_word(make_vec(32767, 32767, 32767, 32767));
        send_word(make_vec(-32768, -32768, -32768, -32768));
        send_word(make_vec(1, 1, 1, 1));
        send_word(make_vec(0, 0, 0, 0));
        idle_sender(1);

        load_uniform(16'h8000);
        send_word(make_vec(-32768, -32768, -32768, -32768));
        send_word(make_vec(32767, 32767, 32767, 32767));
        send_word(make_vec(-1, -1, -1, -1));
        idle_sender(1);

        for (int p = 0; p < N_PHASES; p++) begin
            kind = t_mat_kind'(p % 6);
            for (int i = 0; i < 8; i++) regs[i] = {coef_half(kind), coef_half(kind)};
            load_matrix(regs);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_word(random_vec());
                if (!no_gaps) idle_sender(pick_gap());
            end
            idle_sender(1);
        end

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            sb.report_mismatch($sformatf("%0d words never came out",
                sb.pending_results.size()));
        end
        $display("Checked %0d transformed words under %0d coefficient matrices, %0d clipped.",
            sb.n_words, n_settings, sb.n_clipped);
        if (sb.n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches found.", sb.n_errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
